[src/mi3_pkg.sv]
// ----------------------------------------------------------------------------
// mi3_pkg: shared widths, tables and types for the 3x3 matrix inverter
// Fixed-point formats, cofactor product index tables and the record that
// travels down the divider pipeline.
// ----------------------------------------------------------------------------
package mi3_pkg;

   // field formats
   localparam int IN_W     = 16;   // matrix element width, Q8.8
   localparam int OUT_W    = 32;   // inverse element width, Q16.16
   localparam int IN_FRAC  = 8;
   localparam int OUT_FRAC = 16;
   localparam int DET_W    = 50;   // determinant field width, Q26.24
   localparam int LANES    = 9;    // elements per matrix

   // internal widths
   localparam int PROD_W = 2 * IN_W;          // element x element
   localparam int COF_W  = 2 * IN_W + 1;      // difference of two products
   localparam int DP_W   = IN_W + COF_W;      // element x cofactor
   localparam int DETF_W = 3 * IN_W + 4;      // full determinant sum
   localparam int MAG_W  = DETF_W;            // determinant magnitude
   localparam int SHIFT  = IN_FRAC + OUT_FRAC; // numerator scaling
   localparam int Q_W    = OUT_W;             // quotient bits kept
   localparam int NUM_W  = COF_W + SHIFT;
   localparam int NUMX_W = NUM_W + Q_W;
   localparam int CMP_W  = (NUM_W > MAG_W) ? NUM_W : MAG_W;
   localparam int DIV_STEPS = Q_W;

   // stream widths
   localparam int REQ_DATA_W = ((LANES * IN_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((LANES * OUT_W + DET_W + 7) / 8) * 8;

   // output skid queue
   localparam int FIFO_DEPTH = 2;
   localparam int CNT_W      = 2;

   // saturation values
   localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};
   localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};

   // cofactor k = m[PA_X]*m[PA_Y] - m[PB_X]*m[PB_Y], element index row*3+col
   localparam int unsigned PA_X [LANES] = '{4, 5, 3, 2, 0, 1, 1, 2, 0};
   localparam int unsigned PA_Y [LANES] = '{8, 6, 7, 7, 8, 6, 5, 3, 4};
   localparam int unsigned PB_X [LANES] = '{5, 3, 4, 1, 2, 0, 2, 0, 1};
   localparam int unsigned PB_Y [LANES] = '{7, 8, 6, 8, 6, 7, 4, 5, 3};

   // inverse element (i,j) takes cofactor (j,i)
   localparam int unsigned TR [LANES] = '{0, 3, 6, 1, 4, 7, 2, 5, 8};

   // record carried through the long division stages
   typedef struct packed {
      logic [LANES-1:0][MAG_W-1:0] rem;
      logic [LANES-1:0][Q_W-1:0]   num;
      logic [LANES-1:0][Q_W-1:0]   quo;
      logic [LANES-1:0]            neg;
      logic [LANES-1:0]            ovf;
      logic [MAG_W-1:0]            mag;
      logic                        sing;
      logic [DET_W-1:0]            det;
   } mi3_div_type;

endpackage

[src/mi3_front.sv]
// ----------------------------------------------------------------------------
// mi3_front: cofactors, determinant and divider setup
// Six register stages: products, cofactors, row-1 products, determinant sum,
// magnitudes and signs, then numerator alignment and overflow check.
// ----------------------------------------------------------------------------
module mi3_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [mi3_pkg::REQ_DATA_W-1:0] in_data,
   output logic                          out_valid,
   output mi3_pkg::mi3_div_type          out_data
);

   logic signed [mi3_pkg::IN_W-1:0]   m [mi3_pkg::LANES];

   logic signed [mi3_pkg::PROD_W-1:0] pa_in [mi3_pkg::LANES];
   logic signed [mi3_pkg::PROD_W-1:0] pb_in [mi3_pkg::LANES];
   logic signed [mi3_pkg::PROD_W-1:0] pa_ff [mi3_pkg::LANES];
   logic signed [mi3_pkg::PROD_W-1:0] pb_ff [mi3_pkg::LANES];
   logic signed [mi3_pkg::IN_W-1:0]   row_a_ff [3];
   logic                              va_ff;

   logic signed [mi3_pkg::COF_W-1:0]  cof_b_in [mi3_pkg::LANES];
   logic signed [mi3_pkg::COF_W-1:0]  cof_b_ff [mi3_pkg::LANES];
   logic signed [mi3_pkg::IN_W-1:0]   row_b_ff [3];
   logic                              vb_ff;

   logic signed [mi3_pkg::DP_W-1:0]   dp_c_in [3];
   logic signed [mi3_pkg::DP_W-1:0]   dp_c_ff [3];
   logic signed [mi3_pkg::COF_W-1:0]  cof_c_ff [mi3_pkg::LANES];
   logic                              vc_ff;

   logic signed [mi3_pkg::DETF_W-1:0] det_d_in;
   logic signed [mi3_pkg::DETF_W-1:0] det_d_ff;
   logic signed [mi3_pkg::COF_W-1:0]  cof_d_ff [mi3_pkg::LANES];
   logic                              vd_ff;

   logic [mi3_pkg::MAG_W-1:0]         mag_e_in;
   logic [mi3_pkg::MAG_W-1:0]         mag_e_ff;
   logic                              dneg_e_ff;
   logic                              sing_e_ff;
   logic [mi3_pkg::DET_W-1:0]         det_e_ff;
   logic [mi3_pkg::COF_W-1:0]         cabs_e_in [mi3_pkg::LANES];
   logic [mi3_pkg::COF_W-1:0]         cabs_e_ff [mi3_pkg::LANES];
   logic [mi3_pkg::LANES-1:0]         cneg_e_ff;
   logic                              ve_ff;

   mi3_pkg::mi3_div_type              div_in;
   mi3_pkg::mi3_div_type              div_ff;
   logic                              vf_ff;

   // unpack elements, lowest field first
   always_comb begin
      for (int k = 0; k < mi3_pkg::LANES; k++) begin
         m[k] = in_data[k*mi3_pkg::IN_W +: mi3_pkg::IN_W];
      end
   end

   // stage A: the eighteen element products
   always_comb begin
      for (int k = 0; k < mi3_pkg::LANES; k++) begin
         pa_in[k] = m[mi3_pkg::PA_X[k]] * m[mi3_pkg::PA_Y[k]];
         pb_in[k] = m[mi3_pkg::PB_X[k]] * m[mi3_pkg::PB_Y[k]];
      end
   end

   // stage B: cofactors
   always_comb begin
      for (int k = 0; k < mi3_pkg::LANES; k++) begin
         cof_b_in[k] = mi3_pkg::COF_W'(pa_ff[k]) - mi3_pkg::COF_W'(pb_ff[k]);
      end
   end

   // stage C: row 1 times its cofactors
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         dp_c_in[j] = mi3_pkg::DP_W'(row_b_ff[j]) * mi3_pkg::DP_W'(cof_b_ff[j]);
      end
   end

   // stage D: determinant sum
   assign det_d_in = mi3_pkg::DETF_W'(dp_c_ff[0]) + mi3_pkg::DETF_W'(dp_c_ff[1])
                   + mi3_pkg::DETF_W'(dp_c_ff[2]);

   // stage E: magnitudes
   assign mag_e_in = det_d_ff[mi3_pkg::DETF_W-1] ? mi3_pkg::MAG_W'(-det_d_ff)
                                                 : mi3_pkg::MAG_W'(det_d_ff);
   always_comb begin
      for (int k = 0; k < mi3_pkg::LANES; k++) begin
         cabs_e_in[k] = cof_d_ff[k][mi3_pkg::COF_W-1] ? mi3_pkg::COF_W'(-cof_d_ff[k])
                                                      : mi3_pkg::COF_W'(cof_d_ff[k]);
      end
   end

   // stage F: align numerators, check quotient overflow, seed remainders
   always_comb begin
      logic [mi3_pkg::NUMX_W-1:0] numx;
      logic [mi3_pkg::NUM_W-1:0]  top;
      div_in      = '0;
      div_in.mag  = mag_e_ff;
      div_in.sing = sing_e_ff;
      div_in.det  = det_e_ff;
      for (int l = 0; l < mi3_pkg::LANES; l++) begin
         numx = {{mi3_pkg::Q_W{1'b0}}, cabs_e_ff[mi3_pkg::TR[l]], {mi3_pkg::SHIFT{1'b0}}};
         top  = numx[mi3_pkg::NUMX_W-1:mi3_pkg::Q_W];
         div_in.rem[l] = mi3_pkg::MAG_W'(top);
         div_in.num[l] = numx[mi3_pkg::Q_W-1:0];
         div_in.quo[l] = '0;
         div_in.neg[l] = cneg_e_ff[mi3_pkg::TR[l]] ^ dneg_e_ff;
         div_in.ovf[l] = mi3_pkg::CMP_W'(top) >= mi3_pkg::CMP_W'(mag_e_ff);
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff    <= pa_in;
         pb_ff    <= pb_in;
         for (int j = 0; j < 3; j++) begin
            row_a_ff[j] <= m[j];
         end
         cof_b_ff <= cof_b_in;
         row_b_ff <= row_a_ff;
         dp_c_ff  <= dp_c_in;
         cof_c_ff <= cof_b_ff;
         det_d_ff <= det_d_in;
         cof_d_ff <= cof_c_ff;
         mag_e_ff <= mag_e_in;
         dneg_e_ff <= det_d_ff[mi3_pkg::DETF_W-1];
         sing_e_ff <= (det_d_ff == '0);
         det_e_ff <= det_d_ff[mi3_pkg::DET_W-1:0];
         cabs_e_ff <= cabs_e_in;
         for (int k = 0; k < mi3_pkg::LANES; k++) begin
            cneg_e_ff[k] <= cof_d_ff[k][mi3_pkg::COF_W-1];
         end
         div_ff   <= div_in;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
         vf_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
         ve_ff <= vd_ff;
         vf_ff <= ve_ff;
      end
   end

   assign out_valid = vf_ff;
   assign out_data  = div_ff;

endmodule

[src/mi3_div_stage.sv]
// ----------------------------------------------------------------------------
// mi3_div_stage: one restoring division step for all nine lanes
// Shifts the next numerator bit into each remainder, subtracts the
// determinant magnitude where it fits and records one quotient bit.
// ----------------------------------------------------------------------------
module mi3_div_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  mi3_pkg::mi3_div_type in_data,
   output logic                 out_valid,
   output mi3_pkg::mi3_div_type out_data
);

   mi3_pkg::mi3_div_type step_in;
   mi3_pkg::mi3_div_type step_ff;
   logic                 valid_ff;

   // trial subtract per lane
   always_comb begin
      logic [mi3_pkg::MAG_W:0] t;
      logic                    ge;
      step_in = in_data;
      for (int l = 0; l < mi3_pkg::LANES; l++) begin
         t  = {in_data.rem[l], in_data.num[l][mi3_pkg::Q_W-1]};
         ge = t >= {1'b0, in_data.mag};
         step_in.rem[l] = ge ? mi3_pkg::MAG_W'(t - {1'b0, in_data.mag})
                             : mi3_pkg::MAG_W'(t);
         step_in.num[l] = in_data.num[l] << 1;
         step_in.quo[l] = {in_data.quo[l][mi3_pkg::Q_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = step_ff;

endmodule

[src/mi3_out.sv]
// ----------------------------------------------------------------------------
// mi3_out: sign, saturation and result queue
// Applies quotient sign and Q16.16 saturation, zeroes singular results and
// holds up to two finished results for the response channel.
// ----------------------------------------------------------------------------
module mi3_out (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  mi3_pkg::mi3_div_type           in_data,
   output logic                           en,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [mi3_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tuser
);

   logic [mi3_pkg::RSP_DATA_W-1:0] wdata;
   logic [mi3_pkg::RSP_DATA_W-1:0] data_ff [mi3_pkg::FIFO_DEPTH];
   logic                           user_ff [mi3_pkg::FIFO_DEPTH];
   logic                           wr_ptr_ff;
   logic                           rd_ptr_ff;
   logic [mi3_pkg::CNT_W-1:0]      count_ff;
   logic [mi3_pkg::CNT_W-1:0]      count_in;
   logic                           wr;
   logic                           rd;

   // sign and saturate each lane, pack lowest field first
   always_comb begin
      logic [mi3_pkg::Q_W-1:0] q;
      logic                    sat;
      logic [mi3_pkg::OUT_W-1:0] r;
      wdata = '0;
      for (int l = 0; l < mi3_pkg::LANES; l++) begin
         q = in_data.quo[l];
         if (in_data.neg[l]) begin
            sat = in_data.ovf[l] | (q > mi3_pkg::SAT_NEG);
            r   = sat ? mi3_pkg::SAT_NEG : -q;
         end else begin
            sat = in_data.ovf[l] | q[mi3_pkg::Q_W-1];
            r   = sat ? mi3_pkg::SAT_POS : q;
         end
         if (in_data.sing) begin
            r = '0;
         end
         wdata[l*mi3_pkg::OUT_W +: mi3_pkg::OUT_W] = r;
      end
      wdata[mi3_pkg::LANES*mi3_pkg::OUT_W +: mi3_pkg::DET_W] = in_data.det;
   end

   // queue control
   assign en       = (count_ff != mi3_pkg::CNT_W'(mi3_pkg::FIFO_DEPTH));
   assign wr       = in_valid && en;
   assign rd       = rsp_tvalid && rsp_tready;
   assign count_in = count_ff + mi3_pkg::CNT_W'(wr) - mi3_pkg::CNT_W'(rd);

   always_ff @(posedge clock) begin
      if (wr) begin
         data_ff[wr_ptr_ff] <= wdata;
         user_ff[wr_ptr_ff] <= in_data.sing;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (wr) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (rd) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = data_ff[rd_ptr_ff];
   assign rsp_tuser  = user_ff[rd_ptr_ff];

   // queue never holds more than its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= mi3_pkg::CNT_W'(mi3_pkg::FIFO_DEPTH))
      else $error("result queue overfilled");

   // a singular result carries a zero inverse and a zero determinant
   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("singular result with nonzero payload");

   // a transaction written while one is read leaves the fill level unchanged
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      wr && rd |=> $stable(count_ff))
      else $error("queue count moved on simultaneous write and read");

endmodule

[src/matrix3_inverse.sv]
// ----------------------------------------------------------------------------
// matrix3_inverse: streaming 3x3 matrix inverter by adjugate
// Throughput: one matrix per cycle unless stalled; 6 front stages and 32
// divider stages, one quotient bit per stage, all stages moving together.
// req_tready drops only when both entries of the result queue are full.
// Reset (synchronous, active high) clears all valid bits and the queue.
// ----------------------------------------------------------------------------
module matrix3_inverse (
   input  logic                           clock,
   input  logic                           reset,
   // request: a11 a12 a13 a21 a22 a23 a31 a32 a33, 16 bits each from bit 0
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [mi3_pkg::REQ_DATA_W-1:0] req_tdata,
   // response: r11..r33 (32 bits each from bit 0), determinant (50 bits)
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [mi3_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // response user: is_singular
   output logic                           rsp_tuser
);

   logic                 en;
   logic                 dv [mi3_pkg::DIV_STEPS+1];
   mi3_pkg::mi3_div_type dd [mi3_pkg::DIV_STEPS+1];

   assign req_tready = en;

   // cofactors, determinant and divider setup
   mi3_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_data   (req_tdata),
      .out_valid (dv[0]),
      .out_data  (dd[0])
   );

   // one quotient bit per stage
   for (genvar s = 0; s < mi3_pkg::DIV_STEPS; s++) begin : g_div
      mi3_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (dv[s]),
         .in_data   (dd[s]),
         .out_valid (dv[s+1]),
         .out_data  (dd[s+1])
      );
   end

   // saturation and result queue
   mi3_out u_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (dv[mi3_pkg::DIV_STEPS]),
      .in_data    (dd[mi3_pkg::DIV_STEPS]),
      .en         (en),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the 3x3 adjugate matrix inverter
// Streams directed and random matrices through the block under several
// idle/stall mixes, predicts determinant, singular flag and saturated Q16.16
// inverse for each accepted transaction and checks responses in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

typedef struct {
   logic signed [31:0] inv [9];
   logic               sing;
   logic [49:0]        det;
} inv_result_type;

class inverse_scoreboard;
   inv_result_type pending [$];
   int             errors;

   // Q16.16 quotient of a cofactor by the determinant, toward zero, saturated
   static function logic signed [31:0] scaled_div(longint num, longint den);
      logic [127:0] a, d, q;
      logic         neg;
      neg = (num < 0) != (den < 0);
      a = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      q = (a << 24) / d;
      if (neg) begin
         if (q > 128'h8000_0000) return 32'sh8000_0000;
         return -q[31:0];
      end
      if (q > 128'h7fff_ffff) return 32'sh7fff_ffff;
      return q[31:0];
   endfunction

   // note an accepted matrix and queue its expected response
   function void note_matrix(logic [mi3_pkg::REQ_DATA_W-1:0] data);
      longint         m [9];
      longint         c [9];
      longint         d;
      inv_result_type r;
      for (int k = 0; k < 9; k++) m[k] = $signed(data[16*k +: 16]);
      c[0] = m[4]*m[8] - m[5]*m[7];
      c[1] = m[5]*m[6] - m[3]*m[8];
      c[2] = m[3]*m[7] - m[4]*m[6];
      c[3] = m[2]*m[7] - m[1]*m[8];
      c[4] = m[0]*m[8] - m[2]*m[6];
      c[5] = m[1]*m[6] - m[0]*m[7];
      c[6] = m[1]*m[5] - m[2]*m[4];
      c[7] = m[2]*m[3] - m[0]*m[5];
      c[8] = m[0]*m[4] - m[1]*m[3];
      d = m[0]*c[0] + m[1]*c[1] + m[2]*c[2];
      r.det  = d[49:0];
      r.sing = (d == 0);
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            r.inv[i*3+j] = r.sing ? 32'sd0 : scaled_div(c[j*3+i], d);
      pending.push_back(r);
   endfunction

   // compare one response against the oldest expectation
   function void check_response(logic [mi3_pkg::RSP_DATA_W-1:0] data, logic user);
      inv_result_type e;
      if (pending.size() == 0) begin
         $display("%0t: unexpected response %h", $time, data);
         errors++;
         return;
      end
      e = pending.pop_front();
      for (int k = 0; k < 9; k++)
         if (data[32*k +: 32] !== e.inv[k]) begin
            $display("%0t: r%0d%0d expected %h actual %h", $time, k/3+1, k%3+1,
                     e.inv[k], data[32*k +: 32]);
            errors++;
         end
      if (data[288 +: 50] !== e.det) begin
         $display("%0t: determinant expected %h actual %h", $time, e.det,
                  data[288 +: 50]);
         errors++;
      end
      if (user !== e.sing) begin
         $display("%0t: is_singular expected %b actual %b", $time, e.sing, user);
         errors++;
      end
   endfunction
endclass

module testbench;

   logic                           clock = 0;
   logic                           reset = 1;
   logic                           req_tvalid = 0;
   logic                           req_tready;
   logic [mi3_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 0;
   logic [mi3_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tuser;

   inverse_scoreboard board = new();
   int  send_idle_pct  = 0;
   int  recv_stall_pct = 0;
   bit  hold_off       = 0;
   int  quiet_cycles   = 0;

   matrix3_inverse dut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // receiver: random stalls, forced low during the hold-off
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_response(rsp_tdata, rsp_tuser);
      rsp_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 2000) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // offer one matrix, with optional idle cycles first, until accepted
   task automatic send_matrix(logic [mi3_pkg::REQ_DATA_W-1:0] m);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= m;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_matrix(m);
   endtask

   function automatic logic [15:0] rand_elem();
      case ($urandom_range(5))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return 16'($signed($urandom_range(512)) - 256);
         3:       return 16'($signed($urandom_range(8)) - 4);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [143:0] rand_matrix();
      logic [143:0] m;
      int           kind;
      for (int k = 0; k < 9; k++) m[16*k +: 16] = rand_elem();
      kind = $urandom_range(9);
      // singular shapes: repeated rows, zero column
      if (kind == 0) m[96 +: 48] = m[48 +: 48];
      if (kind == 1) m[48 +: 48] = m[0 +: 48];
      if (kind == 2) begin
         m[0 +: 16] = 0; m[48 +: 16] = 0; m[96 +: 16] = 0;
      end
      return m;
   endfunction

   task automatic run_phase(int n, int idle, int stall);
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      repeat (n) send_matrix(rand_matrix());
   endtask

   initial begin
      logic [143:0] one;
      one = '0;
      one[0 +: 16] = 16'h0100; one[64 +: 16] = 16'h0100; one[128 +: 16] = 16'h0100;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: identity, zero, extremes, scalings, saturating cases
      send_matrix(one);
      send_matrix('0);
      send_matrix({9{16'h7fff}});
      send_matrix({9{16'h8000}});
      send_matrix({16'h8000, 16'h0, 16'h0, 16'h0, 16'h8000, 16'h0, 16'h0, 16'h0,
                   16'h8000});
      send_matrix({16'h7fff, 16'h0, 16'h0, 16'h0, 16'h7fff, 16'h0, 16'h0, 16'h0,
                   16'h7fff});
      send_matrix({16'h0001, 16'h0, 16'h0, 16'h0, 16'h0001, 16'h0, 16'h0, 16'h0,
                   16'h0001});
      send_matrix({16'hffff, 16'h0, 16'h0, 16'h0, 16'h0001, 16'h0, 16'h0, 16'h0,
                   16'h0001});
      send_matrix({16'h7fff, 16'h8000, 16'h0, 16'h8000, 16'h7fff, 16'h0, 16'h0,
                   16'h0, 16'h0001});
      send_matrix({16'h0100, 16'h0200, 16'h0300, 16'h0400, 16'h0500, 16'h0600,
                   16'h0700, 16'h0800, 16'h0a00});
      send_matrix({16'h0001, 16'h7fff, 16'h0, 16'h8000, 16'h0001, 16'h0, 16'h0,
                   16'h0, 16'h7fff});
      send_matrix({16'h5555, 16'haaaa, 16'h1234, 16'hedcb, 16'h0f0f, 16'hf0f0,
                   16'h0001, 16'h8001, 16'h7ffe});

      run_phase(300, 0, 0);
      run_phase(200, 80, 0);
      run_phase(200, 0, 80);
      run_phase(200, 7, 7);

      // long receiver hold-off while the sender keeps offering
      fork
         begin
            hold_off = 1;
            repeat (300) @(posedge clock);
            hold_off = 0;
         end
         run_phase(150, 0, 0);
      join
      run_phase(250, 7, 7);
      req_tvalid <= 0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (board.errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule

[filelist.f]
src/mi3_pkg.sv
src/mi3_front.sv
src/mi3_div_stage.sv
src/mi3_out.sv
src/matrix3_inverse.sv
bench/testbench.sv
